// ===== rtl/buzzer_tone_and_melody_player_assert.svh =====
// Assertion macros for the buzzer player checker.
`ifndef BUZZER_TONE_AND_MELODY_PLAYER_ASSERT_SVH
`define BUZZER_TONE_AND_MELODY_PLAYER_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while in reset.
`define BTM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, sampled on clk and switched off while in reset.
`define BTM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/btm_pkg.sv =====
// Package: command and status codes, datapath operations, link types and the melody ROM.
`timescale 1ns / 1ps

package btm_pkg;

	localparam int CMD_W = 3;
	localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_BEEP      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PLAY      = 3'd2;
	localparam logic [CMD_W-1:0] CMD_STOP_BEEP = 3'd3;
	localparam logic [CMD_W-1:0] CMD_STOP_TUNE = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BUSY     = 2'd1;
	localparam logic [1:0] ST_BAD_TUNE = 2'd2;
	localparam logic [1:0] ST_BAD_FREQ = 2'd3;

	localparam logic [1:0] NUM_TUNES = 2'd3;

	// The divider handles 1000 * TICK_MS up to 100000, which needs 17 bits.
	localparam int DIV_W     = 17;
	localparam int DIV_CNT_W = 5;
	localparam int ROM_AW    = 5;

	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
	localparam logic [OP_W-1:0] OP_CAPTURE    = 4'd1;
	localparam logic [OP_W-1:0] OP_TICK_BEEP  = 4'd2;
	localparam logic [OP_W-1:0] OP_TICK_TUNE  = 4'd3;
	localparam logic [OP_W-1:0] OP_SAVE_MS    = 4'd5;
	localparam logic [OP_W-1:0] OP_DIV_HP     = 4'd6;
	localparam logic [OP_W-1:0] OP_SAVE_HP    = 4'd7;
	localparam logic [OP_W-1:0] OP_DIV_TG     = 4'd8;
	localparam logic [OP_W-1:0] OP_COMMIT     = 4'd9;
	localparam logic [OP_W-1:0] OP_ADVANCE    = 4'd10;
	localparam logic [OP_W-1:0] OP_PLAY       = 4'd11;
	localparam logic [OP_W-1:0] OP_STOP_BEEP  = 4'd12;
	localparam logic [OP_W-1:0] OP_STOP_TUNE  = 4'd13;
	localparam logic [OP_W-1:0] OP_SET_STATUS = 4'd14;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [1:0]      code;
		logic            out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] item_cmd;
		logic             sel_bad;
		logic             div_done;
		logic             toggles_nz;
		logic             freq_zero;
		logic             hp_zero;
		logic             note_go;
	} dp_stat_t;

	function automatic logic [15:0] note_hz(input logic [ROM_AW-1:0] a);
		logic [15:0] r;
		case (a)
			5'd0:    r = 16'd300;
			5'd1:    r = 16'd500;
			5'd2:    r = 16'd300;
			5'd3:    r = 16'd200;
			5'd4:    r = 16'd500;
			5'd5:    r = 16'd300;
			5'd6:    r = 16'd200;
			5'd7:    r = 16'd300;
			5'd8:    r = 16'd200;
			5'd9:    r = 16'd500;
			5'd10:   r = 16'd200;
			5'd11:   r = 16'd600;
			5'd12:   r = 16'd500;
			5'd13:   r = 16'd100;
			5'd14:   r = 16'd300;
			5'd15:   r = 16'd150;
			5'd16:   r = 16'd450;
			5'd17:   r = 16'd500;
			5'd18:   r = 16'd250;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] note_ms(input logic [ROM_AW-1:0] a);
		logic [15:0] r;
		case (a)
			5'd0:    r = 16'd500;
			5'd1:    r = 16'd200;
			5'd2:    r = 16'd100;
			5'd3:    r = 16'd300;
			5'd4:    r = 16'd400;
			5'd5:    r = 16'd100;
			5'd6:    r = 16'd300;
			5'd7:    r = 16'd100;
			5'd8:    r = 16'd300;
			5'd9:    r = 16'd400;
			5'd10:   r = 16'd100;
			5'd11:   r = 16'd100;
			5'd12:   r = 16'd50;
			5'd13:   r = 16'd100;
			5'd14:   r = 16'd50;
			5'd15:   r = 16'd50;
			5'd16:   r = 16'd50;
			5'd17:   r = 16'd50;
			5'd18:   r = 16'd200;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	function automatic logic [ROM_AW-1:0] tune_base(input logic [1:0] t);
		logic [ROM_AW-1:0] r;
		case (t)
			2'd1:    r = 5'd10;
			2'd2:    r = 5'd12;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] tune_len(input logic [1:0] t);
		logic [3:0] r;
		case (t)
			2'd0:    r = 4'd10;
			2'd1:    r = 4'd2;
			2'd2:    r = 4'd7;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/btm_ctrl.sv =====
// Controller state machine: sequences each command word through the datapath.
`timescale 1ns / 1ps

module btm_ctrl
	import btm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  dp_cmd
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_DISPATCH  = 4'd1;
	localparam logic [3:0] S_TICK_TUNE = 4'd2;
	localparam logic [3:0] S_NOTE_MS   = 4'd3;
	localparam logic [3:0] S_CHECK     = 4'd5;
	localparam logic [3:0] S_WAIT_HP   = 4'd6;
	localparam logic [3:0] S_CHECK_HP  = 4'd7;
	localparam logic [3:0] S_WAIT_TG   = 4'd8;
	localparam logic [3:0] S_ADV       = 4'd9;
	localparam logic [3:0] S_RESP      = 4'd10;

	logic [3:0] state_q, state_d;
	logic       from_tune_q, from_tune_d;
	logic       out_valid_q;
	logic [3:0] beep_end;

	// A beep started by the melody goes on to advance the note pointer.
	assign beep_end  = from_tune_q ? S_ADV : S_RESP;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		from_tune_d = from_tune_q;
		dp_cmd      = '{op: OP_NONE, code: ST_OK, out_load: 1'b0};
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					dp_cmd.op = OP_CAPTURE;
					state_d   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_RESP;
				case (stat.item_cmd)
					CMD_TICK: begin
						dp_cmd.op = OP_TICK_BEEP;
						state_d   = S_TICK_TUNE;
					end
					CMD_BEEP: begin
						dp_cmd.op   = OP_SAVE_MS;
						from_tune_d = 1'b0;
						state_d     = S_CHECK;
					end
					CMD_PLAY: begin
						if (stat.sel_bad) begin
							dp_cmd.op   = OP_SET_STATUS;
							dp_cmd.code = ST_BAD_TUNE;
						end else begin
							dp_cmd.op = OP_PLAY;
						end
					end
					CMD_STOP_BEEP: dp_cmd.op = OP_STOP_BEEP;
					CMD_STOP_TUNE: dp_cmd.op = OP_STOP_TUNE;
					default:       dp_cmd.op = OP_NONE;
				endcase
			end
			S_TICK_TUNE: begin
				dp_cmd.op = OP_TICK_TUNE;
				if (stat.note_go) begin
					from_tune_d = 1'b1;
					state_d     = S_NOTE_MS;
				end else begin
					state_d = S_RESP;
				end
			end
			S_NOTE_MS: begin
				dp_cmd.op = OP_SAVE_MS;
				state_d   = S_CHECK;
			end
			S_CHECK: begin
				if (stat.toggles_nz || stat.freq_zero) begin
					// A refused note beep leaves the tick status at ok.
					if (!from_tune_q) begin
						dp_cmd.op   = OP_SET_STATUS;
						dp_cmd.code = stat.toggles_nz ? ST_BUSY : ST_BAD_FREQ;
					end
					state_d = beep_end;
				end else begin
					dp_cmd.op = OP_DIV_HP;
					state_d   = S_WAIT_HP;
				end
			end
			S_WAIT_HP: begin
				if (stat.div_done) begin
					dp_cmd.op = OP_SAVE_HP;
					state_d   = S_CHECK_HP;
				end
			end
			S_CHECK_HP: begin
				if (stat.hp_zero) begin
					if (!from_tune_q) begin
						dp_cmd.op   = OP_SET_STATUS;
						dp_cmd.code = ST_BAD_FREQ;
					end
					state_d = beep_end;
				end else begin
					dp_cmd.op = OP_DIV_TG;
					state_d   = S_WAIT_TG;
				end
			end
			S_WAIT_TG: begin
				if (stat.div_done) begin
					dp_cmd.op = OP_COMMIT;
					state_d   = beep_end;
				end
			end
			S_ADV: begin
				dp_cmd.op = OP_ADVANCE;
				state_d   = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					dp_cmd.out_load = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			from_tune_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			from_tune_q <= from_tune_d;
			if (dp_cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/btm_dp.sv =====
// Datapath: buzzer and timer state, melody ROM lookup, serial divider and result register.
`timescale 1ns / 1ps

module btm_dp
	import btm_pkg::*;
#(
	parameter int TICK_MS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [2:0]  cmd,
	input  logic [15:0] tone_frequency,
	input  logic [15:0] duration_ms,
	input  logic [1:0]  tune_select,
	input  dp_cmd_t     dp_cmd,
	output dp_stat_t    stat,
	output logic        buzzer_level,
	output logic [1:0]  status,
	output logic        beep_running,
	output logic        tune_running
);

	localparam logic [DIV_W-1:0] HP_NUM = DIV_W'(1000 * TICK_MS);

	// Duration in ticks by reciprocal multiplication; with a 23-bit shift the rounded-up
	// reciprocal gives the exact quotient for every 16-bit duration and TICK_MS up to 100.
	localparam int          MS_SHIFT = 23;
	localparam logic [23:0] MS_RECIP = 24'((2**MS_SHIFT + TICK_MS - 1) / TICK_MS);

	// Captured word and beep operands.
	logic [CMD_W-1:0] item_cmd_q;
	logic [1:0]       item_sel_q;
	logic [15:0]      op_freq_q;
	logic [15:0]      op_ms_q;
	logic [15:0]      ms_ticks_q;
	logic [15:0]      new_hp_q;
	logic [1:0]       status_q;

	// Buzzer and timer state.
	logic        pin_q;
	logic [15:0] half_period_q;
	logic [15:0] toggles_q;
	logic [15:0] beep_timer_q;
	logic        beep_armed_q;
	logic [1:0]  tune_q;
	logic [3:0]  note_idx_q;
	logic [15:0] tune_timer_q;
	logic        tune_armed_q;

	// Restoring divider, one quotient bit per cycle.
	logic [DIV_W-1:0]     div_quo_q;
	logic [15:0]          div_rem_q;
	logic [15:0]          div_den_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [16:0]          div_trial;
	logic                 div_ge;
	logic [16:0]          div_diff;

	// Result register.
	logic       lvl_q;
	logic [1:0] res_status_q;
	logic       beep_run_q;
	logic       tune_run_q;

	logic              note_exists;
	logic [ROM_AW-1:0] rom_addr;
	logic [4:0]        idx_next;
	logic [39:0]       ms_prod;

	assign div_trial = {div_rem_q, div_quo_q[DIV_W-1]};
	assign div_ge    = (div_trial >= {1'b0, div_den_q});
	assign div_diff  = div_trial - {1'b0, div_den_q};

	assign ms_prod = 40'(op_ms_q) * 40'(MS_RECIP);

	assign note_exists = (note_idx_q < tune_len(tune_q));
	assign rom_addr    = tune_base(tune_q) + ROM_AW'(note_idx_q);
	assign idx_next    = {1'b0, note_idx_q} + 5'd1;

	assign stat.item_cmd   = item_cmd_q;
	assign stat.sel_bad    = (item_sel_q >= NUM_TUNES);
	assign stat.div_done   = (div_cnt_q == '0);
	assign stat.toggles_nz = (toggles_q != 16'd0);
	assign stat.freq_zero  = (op_freq_q == 16'd0);
	assign stat.hp_zero    = (new_hp_q == 16'd0);
	assign stat.note_go    = tune_armed_q && (tune_timer_q == 16'd0) && note_exists;

	assign buzzer_level = lvl_q;
	assign status       = res_status_q;
	assign beep_running = beep_run_q;
	assign tune_running = tune_run_q;

	// Operands and the result word carry no reset.
	always_ff @(posedge clk) begin
		case (dp_cmd.op)
			OP_CAPTURE: begin
				item_cmd_q <= cmd;
				item_sel_q <= tune_select;
				op_freq_q  <= tone_frequency;
				op_ms_q    <= duration_ms;
			end
			OP_TICK_TUNE: begin
				if (stat.note_go) begin
					op_freq_q <= note_hz(rom_addr);
					op_ms_q   <= note_ms(rom_addr);
				end
			end
			OP_SAVE_MS: ms_ticks_q <= ms_prod[MS_SHIFT+15:MS_SHIFT];
			OP_SAVE_HP: new_hp_q <= div_quo_q[DIV_W-1] ? 16'hFFFF : div_quo_q[15:0];
			default: ;
		endcase
		if (dp_cmd.out_load) begin
			lvl_q        <= pin_q;
			res_status_q <= status_q;
			beep_run_q   <= beep_armed_q;
			tune_run_q   <= tune_armed_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q         <= 1'b1;
			half_period_q <= '0;
			toggles_q     <= '0;
			beep_timer_q  <= '0;
			beep_armed_q  <= 1'b0;
			tune_q        <= '0;
			note_idx_q    <= '0;
			tune_timer_q  <= '0;
			tune_armed_q  <= 1'b0;
			status_q      <= ST_OK;
			div_quo_q     <= '0;
			div_rem_q     <= '0;
			div_den_q     <= '0;
			div_cnt_q     <= '0;
		end else begin
			if (div_cnt_q != '0) begin
				div_quo_q <= {div_quo_q[DIV_W-2:0], div_ge};
				div_rem_q <= div_ge ? div_diff[15:0] : div_trial[15:0];
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			end
			case (dp_cmd.op)
				OP_CAPTURE: status_q <= ST_OK;
				OP_SET_STATUS: status_q <= dp_cmd.code;
				OP_TICK_BEEP: begin
					if (beep_armed_q) begin
						if (beep_timer_q != 16'd0) begin
							beep_timer_q <= beep_timer_q - 16'd1;
						end else if (toggles_q == 16'd0) begin
							pin_q        <= 1'b0;
							beep_armed_q <= 1'b0;
						end else begin
							toggles_q    <= toggles_q - 16'd1;
							pin_q        <= ~pin_q;
							beep_timer_q <= half_period_q;
						end
					end
				end
				OP_TICK_TUNE: begin
					if (tune_armed_q) begin
						if (tune_timer_q != 16'd0) begin
							tune_timer_q <= tune_timer_q - 16'd1;
						end else begin
							tune_armed_q <= 1'b0;
						end
					end
				end
				OP_DIV_HP: begin
					div_quo_q <= HP_NUM;
					div_rem_q <= '0;
					div_den_q <= op_freq_q;
					div_cnt_q <= DIV_CNT_W'(DIV_W);
				end
				OP_DIV_TG: begin
					div_quo_q <= {1'b0, ms_ticks_q};
					div_rem_q <= '0;
					div_den_q <= new_hp_q;
					div_cnt_q <= DIV_CNT_W'(DIV_W);
				end
				OP_COMMIT: begin
					half_period_q <= new_hp_q;
					toggles_q     <= div_quo_q[15:0];
					pin_q         <= 1'b1;
					beep_timer_q  <= new_hp_q;
					beep_armed_q  <= 1'b1;
				end
				OP_ADVANCE: begin
					note_idx_q <= idx_next[3:0];
					if (idx_next < {1'b0, tune_len(tune_q)}) begin
						tune_timer_q <= ms_ticks_q;
						tune_armed_q <= 1'b1;
					end
				end
				OP_PLAY: begin
					tune_q       <= item_sel_q;
					note_idx_q   <= '0;
					tune_timer_q <= '0;
					tune_armed_q <= 1'b1;
				end
				OP_STOP_BEEP: begin
					toggles_q    <= '0;
					beep_armed_q <= 1'b0;
				end
				OP_STOP_TUNE: tune_armed_q <= 1'b0;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/buzzer_tone_and_melody_player.sv =====
// Top level of the buzzer tone and melody player: controller plus datapath.
`timescale 1ns / 1ps
// Path to the registered result: stop, play and ignored words go from dispatch to the result,
// a tick that starts no note or a beep refused at once passes one more state, a half period
// of zero runs the 17-step divider once, and a started beep or melody note runs it twice.
// Throughput: one word at a time; the next word is accepted once the result is registered.
// Reset (arst_n low, asynchronous): pin level high, all timers disarmed, counts and tune zero.

module buzzer_tone_and_melody_player
	import btm_pkg::*;
#(
	parameter int TICK_MS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [15:0] tone_frequency,
	input  logic [15:0] duration_ms,
	input  logic [1:0]  tune_select,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        buzzer_level,
	output logic [1:0]  status,
	output logic        beep_running,
	output logic        tune_running
);

	// The controller decides, one operation per cycle, what the datapath does with the
	// captured word. The datapath reports back only the flags that steer the sequence.
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// Controller. A tick first serves the beep timer, then the melody timer; when the melody
	// timer expires on a note it runs the same beep sequence as a beep word, and afterwards
	// moves the note pointer and, if another note follows, reloads the melody timer. The
	// result word sits in an output register, so a new word can be accepted while it waits to be taken.
	btm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (dp_stat),
		.dp_cmd    (dp_cmd)
	);

	// Datapath. The half period is 1000 * TICK_MS / frequency, saturated to 16 bits, and
	// the toggle count is (duration / TICK_MS) / half period. A zero frequency or a zero
	// half period is caught before it reaches the divider as a divisor.
	btm_dp #(
		.TICK_MS (TICK_MS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.tone_frequency (tone_frequency),
		.duration_ms    (duration_ms),
		.tune_select    (tune_select),
		.dp_cmd         (dp_cmd),
		.stat           (dp_stat),
		.buzzer_level   (buzzer_level),
		.status         (status),
		.beep_running   (beep_running),
		.tune_running   (tune_running)
	);

endmodule

// ===== rtl/btm_chk.sv =====
// Port-level checker for the buzzer player, bound to the top level.
`timescale 1ns / 1ps
`include "buzzer_tone_and_melody_player_assert.svh"

module btm_chk
	import btm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        buzzer_level,
	input logic [1:0]  status,
	input logic        beep_running,
	input logic        tune_running
);

	// A busy answer means toggles remain, and toggles only remain with the beep timer armed.
	`BTM_ASSERT_NOW(a_busy_armed, out_valid && (status == ST_BUSY), beep_running, "busy without beep")

	// One word is worked on at a time.
	`BTM_ASSERT_NEXT(a_one_word, in_valid && in_ready, !in_ready, "second word taken early")

	// A result that is not taken stays put.
	`BTM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable({buzzer_level, status, beep_running, tune_running}),
		"result changed while stalled")

endmodule

bind buzzer_tone_and_melody_player btm_chk u_btm_chk (.*);

// ===== verif/buzzer_tone_and_melody_player_tb.sv =====
// Self-checking testbench for the buzzer tone and melody player, with its own command predictor.
`timescale 1ns / 1ps

module buzzer_tone_and_melody_player_tb;
	import btm_pkg::*;

	localparam int TICK_MS      = 10;
	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_WORDS = 900;
	localparam int MAX_GAP      = 60;
	// A started beep word runs the divider twice; the drain limit leaves a wide margin
	// over such a word even with a heavily stalling receiver.
	localparam int DRAIN_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 100;
	// The timeout lies well beyond the slowest correct run.
	localparam int TIMEOUT_NS = 10_000_000;

	// Command codes 5 to 7 have no meaning and must be ignored by the block.
	localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic       level;
		logic [1:0] status;
		logic       beeping;
		logic       playing;
	} buzz_outcome_t;

	// The tracker mirrors the buzzer state, predicts the result word of every
	// accepted command and checks the result words against those predictions.
	class buzzer_tracker;
		bit          pin_level;
		bit [15:0]   half_period;
		bit [15:0]   toggles_left;
		bit [15:0]   beep_timer;
		bit          beep_armed;
		bit [1:0]    current_tune;
		bit [3:0]    note_index;
		bit [15:0]   tune_timer;
		bit          tune_armed;

		int unsigned melody_hz[19] = '{300, 500, 300, 200, 500, 300, 200, 300, 200, 500,
			200, 600, 500, 100, 300, 150, 450, 500, 250};
		int unsigned melody_ms[19] = '{500, 200, 100, 300, 400, 100, 300, 100, 300, 400,
			100, 100, 50, 100, 50, 50, 50, 50, 200};
		int unsigned tune_first[4] = '{0, 10, 12, 0};
		int unsigned tune_notes[4] = '{10, 2, 7, 0};

		buzz_outcome_t pending_outcomes[$];
		int unsigned   mismatches;
		int unsigned   results_checked;
		int unsigned   cmd_seen[8];
		int unsigned   status_seen[4];

		function new();
			pin_level    = 1'b1;
			half_period  = '0;
			toggles_left = '0;
			beep_timer   = '0;
			beep_armed   = 1'b0;
			current_tune = '0;
			note_index   = '0;
			tune_timer   = '0;
			tune_armed   = 1'b0;
			mismatches   = 0;
			results_checked = 0;
			foreach (cmd_seen[i]) cmd_seen[i] = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		// Starts a tone, or says why it cannot: a running count makes it busy,
		// and a zero frequency or one that gives no whole tick of half period is refused.
		function logic [1:0] start_tone(int unsigned hz, int unsigned ms);
			int unsigned hp;
			if (toggles_left != 0)
				return ST_BUSY;
			if (hz == 0)
				return ST_BAD_FREQ;
			hp = (1000 * TICK_MS) / hz;
			if (hp > 32'h0000_FFFF)
				hp = 32'h0000_FFFF;
			if (hp == 0)
				return ST_BAD_FREQ;
			half_period  = hp[15:0];
			toggles_left = 16'((ms / TICK_MS) / hp);
			pin_level    = 1'b1;
			beep_timer   = half_period;
			beep_armed   = 1'b1;
			return ST_OK;
		endfunction

		function void take_command(logic [2:0] c, logic [15:0] hz, logic [15:0] ms,
				logic [1:0] sel);
			buzz_outcome_t o;
			logic [1:0]    st;
			int unsigned   idx;
			int unsigned   addr;
			st = ST_OK;
			case (c)
				CMD_TICK: begin
					// The beep timer is served before the tune timer.
					if (beep_armed) begin
						if (beep_timer == 0) begin
							beep_armed = 1'b0;
							if (toggles_left == 0) begin
								pin_level = 1'b0;
							end else begin
								toggles_left = toggles_left - 16'd1;
								pin_level    = ~pin_level;
								beep_timer   = half_period;
								beep_armed   = 1'b1;
							end
						end else begin
							beep_timer = beep_timer - 16'd1;
						end
					end
					if (tune_armed) begin
						if (tune_timer == 0) begin
							tune_armed = 1'b0;
							idx = note_index;
							if (idx < tune_notes[current_tune]) begin
								addr = tune_first[current_tune] + idx;
								// A note refused as busy is skipped, but its wait still runs.
								void'(start_tone(melody_hz[addr], melody_ms[addr]));
								note_index = 4'(idx + 1);
								if (idx + 1 < tune_notes[current_tune]) begin
									tune_timer = 16'(melody_ms[addr] / TICK_MS);
									tune_armed = 1'b1;
								end
							end
						end else begin
							tune_timer = tune_timer - 16'd1;
						end
					end
				end
				CMD_BEEP: begin
					st = start_tone(hz, ms);
				end
				CMD_PLAY: begin
					if (sel >= NUM_TUNES) begin
						st = ST_BAD_TUNE;
					end else begin
						current_tune = sel;
						note_index   = '0;
						tune_timer   = '0;
						tune_armed   = 1'b1;
					end
				end
				CMD_STOP_BEEP: begin
					toggles_left = '0;
					beep_armed   = 1'b0;
				end
				CMD_STOP_TUNE: begin
					tune_armed = 1'b0;
				end
				default: begin
				end
			endcase
			o.level   = pin_level;
			o.status  = st;
			o.beeping = beep_armed;
			o.playing = tune_armed;
			pending_outcomes.push_back(o);
			cmd_seen[c]++;
			status_seen[st]++;
		endfunction

		task report(string what);
			$display("MISMATCH at %0t: %s", $time, what);
			mismatches++;
		endtask

		task check_result(logic level, logic [1:0] st, logic beeping, logic playing);
			buzz_outcome_t want;
			results_checked++;
			if (pending_outcomes.size() == 0) begin
				report($sformatf("result %0d arrived with no command waiting",
					results_checked));
			end else begin
				want = pending_outcomes.pop_front();
				if (level !== want.level)
					report($sformatf("result %0d buzzer_level: expected %0b, got %0b",
						results_checked, want.level, level));
				if (st !== want.status)
					report($sformatf("result %0d status: expected %0d, got %0d",
						results_checked, want.status, st));
				if (beeping !== want.beeping)
					report($sformatf("result %0d beep_running: expected %0b, got %0b",
						results_checked, want.beeping, beeping));
				if (playing !== want.playing)
					report($sformatf("result %0d tune_running: expected %0b, got %0b",
						results_checked, want.playing, playing));
			end
		endtask
	endclass

	// Every input of the block starts at a known value, reset included.
	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic [2:0]  cmd            = CMD_TICK;
	logic [15:0] tone_frequency = '0;
	logic [15:0] duration_ms    = '0;
	logic [1:0]  tune_select    = '0;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic        buzzer_level;
	logic [1:0]  status;
	logic        beep_running;
	logic        tune_running;

	int unsigned sender_idle_pct    = 0;
	int unsigned receiver_stall_pct = 0;

	buzzer_tracker tracker = new();

	buzzer_tone_and_melody_player #(
		.TICK_MS(TICK_MS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.tone_frequency(tone_frequency),
		.duration_ms   (duration_ms),
		.tune_select   (tune_select),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.buzzer_level  (buzzer_level),
		.status        (status),
		.beep_running  (beep_running),
		.tune_running  (tune_running)
	);

	always #(CLK_HALF) clk = ~clk;

	// Safety net: a hung handshake ends the run here.
	initial begin
		#(TIMEOUT_NS);
		$display("Timeout at %0t with %0d results outstanding.", $time,
			tracker.pending_outcomes.size());
		$display("TEST FAILED");
		$finish;
	end

	// Result side. The values read here are the ones that stood before the edge,
	// so a word counts as taken exactly when valid and ready were both high. The
	// ready for the next edge is then drawn against the current stall rate.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				tracker.check_result(buzzer_level, status, beep_running, tune_running);
			out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	// Presents one command word and returns at the edge that takes it. Valid is
	// only lowered when a gap is actually inserted, so back-to-back words keep it
	// high without a second assignment in the same step.
	task automatic send_word(input logic [2:0] c, input logic [15:0] hz,
			input logic [15:0] ms, input logic [1:0] sel);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		cmd            <= c;
		tone_frequency <= hz;
		duration_ms    <= ms;
		tune_select    <= sel;
		do @(posedge clk); while (!in_ready);
		tracker.take_command(c, hz, ms, sel);
	endtask

	// Ticks carry random junk in the unused fields so that every bit moves.
	task automatic send_ticks(input int count);
		repeat (count)
			send_word(CMD_TICK, 16'($urandom()), 16'($urandom()), 2'($urandom()));
	endtask

	initial begin
		int counted;
		int phase;
		int pick;
		int drain;
		logic [15:0] hz;
		logic [15:0] ms;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening, with no idling on either side. The first tick shows
		// the reset state: pin high, nothing armed.
		send_ticks(1);
		send_word(CMD_STOP_BEEP, 16'hFFFF, 16'hFFFF, 2'd3);
		send_word(CMD_STOP_TUNE, 16'h0000, 16'h0000, 2'd0);
		send_word(CMD_UNUSED_LO, 16'd300, 16'd100, 2'd0);
		send_word(CMD_UNUSED_HI, 16'd300, 16'd100, 2'd2);
		// Zero frequency, and frequencies too high for a whole tick of half period.
		send_word(CMD_BEEP, 16'd0, 16'hFFFF, 2'd0);
		send_word(CMD_BEEP, 16'hFFFF, 16'hFFFF, 2'd0);
		send_word(CMD_BEEP, 16'd10001, 16'd100, 2'd0);
		// Highest usable frequency with the longest duration: a huge toggle count,
		// so the next beep and the first melody note are refused as busy.
		send_word(CMD_BEEP, 16'd10000, 16'hFFFF, 2'd0);
		send_word(CMD_BEEP, 16'd300, 16'd100, 2'd0);
		send_word(CMD_PLAY, 16'd0, 16'd0, 2'd0);
		send_ticks(2);
		send_word(CMD_STOP_BEEP, 16'd0, 16'd0, 2'd0);
		// Out-of-range melody, then a short melody restarted by another play.
		send_word(CMD_PLAY, 16'd0, 16'd0, 2'd3);
		send_word(CMD_PLAY, 16'd0, 16'd0, 2'd1);
		send_ticks(1);
		send_word(CMD_PLAY, 16'd0, 16'd0, 2'd2);
		send_ticks(1);
		send_word(CMD_STOP_TUNE, 16'd0, 16'd0, 2'd0);
		send_word(CMD_STOP_BEEP, 16'd0, 16'd0, 2'd0);
		// Lowest frequency with no duration: longest half period, no toggles.
		send_word(CMD_BEEP, 16'd1, 16'd0, 2'd1);
		send_word(CMD_STOP_BEEP, 16'd0, 16'd0, 2'd0);
		// Half period 2 with one toggle: expiry with a count, then the final low.
		send_word(CMD_BEEP, 16'd5000, 16'd20, 2'd0);
		send_ticks(6);

		// Random part in four idling phases. Each episode is one command or a run of ticks;
		// a play or a beep is followed by ticks so that beeps toggle out and melodies advance.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 77; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 77; end
				default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
			endcase
			counted = 0;
			while (counted < RANDOM_WORDS / 4) begin
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					send_word(CMD_PLAY, 16'($urandom()), 16'($urandom()),
						2'($urandom_range(0, 3)));
					pick = $urandom_range(20, 80);
					send_ticks(pick);
					counted += pick + 1;
				end else if (pick < 32) begin
					// Mostly short beeps of a few ticks per half period; now and then
					// a low or arbitrary frequency and an arbitrary duration.
					pick = $urandom_range(0, 99);
					if (pick < 10)
						hz = 16'($urandom_range(0, 15));
					else if (pick < 20)
						hz = 16'($urandom());
					else
						hz = 16'($urandom_range(500, 10000));
					ms = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 400))
						: 16'($urandom());
					send_word(CMD_BEEP, hz, ms, 2'($urandom()));
					pick = $urandom_range(1, 25);
					send_ticks(pick);
					counted += pick + 1;
				end else if (pick < 40) begin
					send_word(CMD_STOP_BEEP, 16'($urandom()), 16'($urandom()), 2'($urandom()));
					counted++;
				end else if (pick < 46) begin
					send_word(CMD_STOP_TUNE, 16'($urandom()), 16'($urandom()), 2'($urandom()));
					counted++;
				end else if (pick < 50) begin
					// Ignored codes do not count toward the word budget.
					send_word(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
						16'($urandom()), 16'($urandom()), 2'($urandom()));
				end else begin
					pick = $urandom_range(1, 10);
					send_ticks(pick);
					counted += pick;
				end
			end
		end

		in_valid <= 1'b0;

		// Let the last results come back, then watch a while for strays.
		drain = 0;
		while (tracker.pending_outcomes.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		if (tracker.pending_outcomes.size() != 0)
			tracker.report($sformatf("%0d expected results never arrived",
				tracker.pending_outcomes.size()));
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d ticks, %0d beeps, %0d plays, %0d beep stops, %0d tune stops.",
			tracker.cmd_seen[CMD_TICK], tracker.cmd_seen[CMD_BEEP], tracker.cmd_seen[CMD_PLAY],
			tracker.cmd_seen[CMD_STOP_BEEP], tracker.cmd_seen[CMD_STOP_TUNE]);
		$display("%0d ok, %0d busy, %0d bad tune, %0d bad freq; %0d results, %0d mismatches.",
			tracker.status_seen[ST_OK], tracker.status_seen[ST_BUSY],
			tracker.status_seen[ST_BAD_TUNE], tracker.status_seen[ST_BAD_FREQ],
			tracker.results_checked, tracker.mismatches);
		if (tracker.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/btm_pkg.sv
rtl/btm_ctrl.sv
rtl/btm_dp.sv
rtl/buzzer_tone_and_melody_player.sv
rtl/btm_chk.sv
verif/buzzer_tone_and_melody_player_tb.sv
